// ----- hdl/md5_pkg.sv -----
// shared types, constants and round tables for the md5 core
package md5_pkg;

    typedef logic [3:0][31:0] t_chain;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam t_chain CHAIN_INIT = {INIT_D, INIT_C, INIT_B, INIT_A};

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'h3f;
    localparam logic [5:0] LAST_RND = 6'd63;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_PRIME = 6'b000100,
        S_ROUND = 6'b001000,
        S_ADD   = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        M_DATA = 2'd0,
        M_PAD1 = 2'd1,
        M_LAST = 2'd2
    } t_mode;

    typedef struct packed {
        logic       load;
        logic       step;
        logic [5:0] rnd;
    } t_round_ctl;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] round_s(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
            4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
            4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
            4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // message word index used by round i
    function automatic logic [3:0] round_g(input logic [5:0] i);
        logic [3:0] r;
        logic [3:0] g;
        r = i[3:0];
        case (i[5:4])
            2'd0:    g = r;
            2'd1:    g = 4'(r * 4'd5 + 4'd1);
            2'd2:    g = 4'(r * 4'd3 + 4'd5);
            2'd3:    g = 4'(r * 4'd7);
            default: g = r;
        endcase
        return g;
    endfunction

endpackage

// ----- hdl/md5_blkbuf.sv -----
// 64-byte block buffer: byte write port, registered 32-bit word read port
module md5_blkbuf
    import md5_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_we,
    input  logic [5:0]  i_waddr,
    input  logic [7:0]  i_wdata,
    input  logic [3:0]  i_raddr,
    output logic [31:0] o_rword
);

    // one 16-entry lane per byte of the little-endian word
    logic [7:0]  r_mem [4][16];
    logic [31:0] r_rword;

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 4; l++) begin
            if (i_we && (i_waddr[1:0] == 2'(l))) begin
                r_mem[l][i_waddr[5:2]] <= i_wdata;
            end
            r_rword[8*l +: 8] <= r_mem[l][i_raddr];
        end
    end

    assign o_rword = r_rword;

endmodule

// ----- hdl/md5_round.sv -----
// md5 round datapath: working words a..d and one round per step
module md5_round
    import md5_pkg::*;
(
    input  logic        i_clk,
    input  t_round_ctl  i_ctl,
    input  logic [31:0] i_w,
    input  t_chain      i_chain,
    output t_chain      o_abcd
);

    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] dbl;
    logic [31:0] rot;

    always_comb begin
        case (i_ctl.rnd[5:4])
            2'd0:    f = r_d ^ (r_b & (r_c ^ r_d));
            2'd1:    f = r_c ^ (r_d & (r_b ^ r_c));
            2'd2:    f = r_b ^ r_c ^ r_d;
            2'd3:    f = r_c ^ (r_b | ~r_d);
            default: f = r_b ^ r_c ^ r_d;
        endcase
        sum = r_a + f + round_k(i_ctl.rnd) + i_w;
        dbl = {sum, sum} << round_s(i_ctl.rnd);
        rot = dbl[63:32];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a <= i_chain[0];
            r_b <= i_chain[1];
            r_c <= i_chain[2];
            r_d <= i_chain[3];
        end else if (i_ctl.step) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= r_b + rot;
        end
    end

    assign o_abcd = {r_d, r_c, r_b, r_a};

endmodule

// ----- hdl/md5_message_digest_core.sv -----
// md5 core: one message byte per beat in, 128-bit digest out as two 64-bit beats
// input is taken only while idle; the 64th byte of a block stalls input for the
// word prime, 64 rounds one per cycle on the round unit and the chaining add
// end of message: pad to the block end, compress each padded block (two when
// fewer than 9 bytes remain), load digest once output empty; first half next cycle
// synchronous active-low reset restores the initial chaining words, empties the output
module md5_message_digest_core
    import md5_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic [0:0]  s_tuser,   // [0] byte_present
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] digest_half
    output logic [0:0]  m_tuser,   // [0] half_index
    output logic        m_tlast    // last_result
);

    t_state      r_state, n_state;
    t_mode       r_mode, n_mode;
    t_chain      r_chain, n_chain;
    logic [63:0] r_bits, n_bits;
    logic [5:0]  r_pos, n_pos;
    logic [5:0]  r_rnd, n_rnd;
    logic        r_eom, n_eom;
    logic        r_need80, n_need80;
    logic        r_lenok, n_lenok;
    logic        r_out_valid;
    logic        r_out_idx;
    logic [63:0] r_out_lo, r_out_hi;

    logic        mem_we;
    logic [5:0]  mem_waddr;
    logic [7:0]  mem_wdata;
    logic [3:0]  mem_raddr;
    logic [31:0] mem_rword;
    t_round_ctl  round_ctl;
    t_chain      abcd;
    logic        emit_load;
    logic [5:0]  pos_after;
    logic [63:0] len_shift;

    md5_blkbuf u_buf (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rword (mem_rword)
    );

    md5_round u_round (
        .i_clk   (i_clk),
        .i_ctl   (round_ctl),
        .i_w     (mem_rword),
        .i_chain (r_chain),
        .o_abcd  (abcd)
    );

    assign s_tready  = (r_state == S_IDLE);
    assign pos_after = s_tuser[0] ? r_pos + 6'd1 : r_pos;
    assign len_shift = r_bits >> {r_pos[2:0], 3'b000};

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_chain   = r_chain;
        n_bits    = r_bits;
        n_pos     = r_pos;
        n_rnd     = r_rnd;
        n_eom     = r_eom;
        n_need80  = r_need80;
        n_lenok   = r_lenok;
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        mem_wdata = s_tdata;
        mem_raddr = round_g(r_rnd + 6'd1);
        round_ctl = '{load: 1'b0, step: 1'b0, rnd: r_rnd};
        emit_load = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser[0]) begin
                        mem_we = 1'b1;
                        n_pos  = r_pos + 6'd1;
                        n_bits = r_bits + 64'd8;
                    end
                    if (s_tuser[0] && (r_pos == LAST_POS)) begin
                        n_state = S_PRIME;
                        n_mode  = M_DATA;
                        n_eom   = s_tlast;
                    end else if (s_tlast) begin
                        n_state  = S_PAD;
                        n_need80 = 1'b1;
                        n_lenok  = (pos_after < LEN_POS);
                    end
                end
            end
            S_PAD: begin
                mem_we   = 1'b1;
                n_need80 = 1'b0;
                n_pos    = r_pos + 6'd1;
                if (r_need80) begin
                    mem_wdata = PAD_MARK;
                end else if (r_lenok && (r_pos >= LEN_POS)) begin
                    mem_wdata = len_shift[7:0];
                end else begin
                    mem_wdata = 8'h00;
                end
                if (r_pos == LAST_POS) begin
                    n_state = S_PRIME;
                    n_mode  = r_lenok ? M_LAST : M_PAD1;
                end
            end
            S_PRIME: begin
                round_ctl.load = 1'b1;
                mem_raddr      = round_g(6'd0);
                n_rnd          = 6'd0;
                n_state        = S_ROUND;
            end
            S_ROUND: begin
                round_ctl.step = 1'b1;
                n_rnd          = r_rnd + 6'd1;
                if (r_rnd == LAST_RND) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                for (int k = 0; k < 4; k++) begin
                    n_chain[k] = r_chain[k] + abcd[k];
                end
                case (r_mode)
                    M_DATA: begin
                        if (r_eom) begin
                            n_state  = S_PAD;
                            n_need80 = 1'b1;
                            n_lenok  = 1'b1;
                            n_eom    = 1'b0;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    M_PAD1: begin
                        n_state  = S_PAD;
                        n_need80 = 1'b0;
                        n_lenok  = 1'b1;
                    end
                    M_LAST: begin
                        n_state = S_EMIT;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_EMIT: begin
                // wait for the previous digest to drain
                if (!r_out_valid) begin
                    emit_load = 1'b1;
                    n_chain   = CHAIN_INIT;
                    n_bits    = 64'd0;
                    n_pos     = 6'd0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= M_DATA;
            r_chain  <= CHAIN_INIT;
            r_bits   <= 64'd0;
            r_pos    <= 6'd0;
            r_rnd    <= 6'd0;
            r_eom    <= 1'b0;
            r_need80 <= 1'b0;
            r_lenok  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_chain  <= n_chain;
            r_bits   <= n_bits;
            r_pos    <= n_pos;
            r_rnd    <= n_rnd;
            r_eom    <= n_eom;
            r_need80 <= n_need80;
            r_lenok  <= n_lenok;
        end
    end

    // digest output register, two beats per message
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_idx   <= 1'b0;
        end else if (emit_load) begin
            r_out_valid <= 1'b1;
            r_out_idx   <= 1'b0;
        end else if (r_out_valid && m_tready) begin
            if (r_out_idx) begin
                r_out_valid <= 1'b0;
                r_out_idx   <= 1'b0;
            end else begin
                r_out_idx <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_out_lo <= {r_chain[1], r_chain[0]};
            r_out_hi <= {r_chain[3], r_chain[2]};
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_idx ? r_out_hi : r_out_lo;
    assign m_tuser  = r_out_idx;
    assign m_tlast  = r_out_idx;

endmodule

// ----- hdl/md5_core_checker.sv -----
// port-level checks for the md5 core, bound to the top level
module md5_core_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    // output stays empty straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("digest beat shown right after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("digest beat dropped while stalled");

    // first half is always followed by the second
    a_second_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tready && !m_tuser[0] |=> m_tvalid && m_tuser[0] && m_tlast)
        else $error("second digest half missing");

    a_half_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tuser[0] == m_tlast))
        else $error("half index and last flag disagree");

    // end of message always leaves idle (padding, or first compressing a full block), so input stalls
    a_eom_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken while closing a message");

endmodule

bind md5_message_digest_core md5_core_checker u_md5_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- tb/sv/md5_digest_checker.sv -----
// channel monitor, digest predictor and scoreboard for the md5 core
module md5_digest_checker
    import md5_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] byte_value
    input  logic [0:0]  i_s_tuser,   // [0] byte_present
    input  logic        i_s_tlast,   // end_of_message
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [63:0] i_m_tdata,   // [63:0] digest_half
    input  logic [0:0]  i_m_tuser,   // [0] half_index
    input  logic        i_m_tlast,   // last_result
    output int          o_pending,
    output int          o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] digest_half;
        logic        half_index;
        logic        last_result;
    } t_digest_half;

    // per-round additive constants, floor(abs(sin(i + 1)) * 2^32)
    logic [31:0] add_const [0:63] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    int shift_amt [0:15] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    logic [31:0]  chain_word [0:3];
    logic [7:0]   block_bytes [0:63];
    logic [63:0]  msg_bits;
    logic [5:0]   fill_pos;
    t_digest_half halves_due [$];
    int           fails = 0;

    function automatic void restart_message();
        for (int k = 0; k < 4; k++) chain_word[k] = CHAIN_INIT[k];
        msg_bits = '0;
        fill_pos = '0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [0:15];
        logic [31:0] a, b, c, d, f, sum, tmp;
        int          g, s;
        for (int k = 0; k < 16; k++)
            w[k] = {block_bytes[4*k+3], block_bytes[4*k+2], block_bytes[4*k+1], block_bytes[4*k]};
        a = chain_word[0];
        b = chain_word[1];
        c = chain_word[2];
        d = chain_word[3];
        for (int r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin
                    f = d ^ (b & (c ^ d));
                    g = r % 16;
                end
                1: begin
                    f = c ^ (d & (b ^ c));
                    g = (5 * r + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * r + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * r) % 16;
                end
            endcase
            s = shift_amt[(r / 16) * 4 + r % 4];
            sum = a + f + add_const[r] + w[g];
            sum = (sum << s) | (sum >> (32 - s));
            tmp = d;
            d = c;
            c = b;
            b = b + sum;
            a = tmp;
        end
        chain_word[0] += a;
        chain_word[1] += b;
        chain_word[2] += c;
        chain_word[3] += d;
    endfunction

    // pad, append the length, run the last block(s) and queue both digest halves
    function automatic void close_message();
        int           p;
        t_digest_half lo, hi;
        p = int'(fill_pos);
        block_bytes[p] = PAD_MARK;
        p = p + 1;
        // no room left for the length: run a padded block first
        if (p > int'(LEN_POS)) begin
            while (p < 64) begin
                block_bytes[p] = 8'h00;
                p = p + 1;
            end
            compress_block();
            p = 0;
        end
        while (p < int'(LEN_POS)) begin
            block_bytes[p] = 8'h00;
            p = p + 1;
        end
        for (int k = 0; k < 8; k++) block_bytes[int'(LEN_POS) + k] = msg_bits[8*k +: 8];
        compress_block();
        lo.digest_half = {chain_word[1], chain_word[0]};
        lo.half_index  = 1'b0;
        lo.last_result = 1'b0;
        hi.digest_half = {chain_word[3], chain_word[2]};
        hi.half_index  = 1'b1;
        hi.last_result = 1'b1;
        halves_due.push_back(lo);
        halves_due.push_back(hi);
        restart_message();
    endfunction

    function automatic void take_item(logic [7:0] value, logic present, logic closes);
        if (present) begin
            block_bytes[fill_pos] = value;
            fill_pos = fill_pos + 6'd1;
            msg_bits = msg_bits + 64'd8;
            if (fill_pos == 6'd0) compress_block();
        end
        if (closes) close_message();
    endfunction

    function automatic void check_half(logic [63:0] data, logic idx, logic last);
        t_digest_half due;
        if (halves_due.size() == 0) begin
            $error("digest beat with none outstanding: %h", data);
            fails++;
            return;
        end
        due = halves_due.pop_front();
        if (data !== due.digest_half) begin
            $error("digest_half mismatch: expected %h, got %h", due.digest_half, data);
            fails++;
        end
        if (idx !== due.half_index) begin
            $error("half_index mismatch: expected %0b, got %0b", due.half_index, idx);
            fails++;
        end
        if (last !== due.last_result) begin
            $error("last_result mismatch: expected %0b, got %0b", due.last_result, last);
            fails++;
        end
    endfunction

    initial restart_message();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_message();
            halves_due.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) take_item(i_s_tdata, i_s_tuser[0], i_s_tlast);
            if (i_m_tvalid && i_m_tready) check_half(i_m_tdata, i_m_tuser[0], i_m_tlast);
        end
        // registered so the stimulus side reads a settled value at the edge
        o_pending    <= halves_due.size();
        o_fail_count <= fails;
    end

endmodule

// ----- tb/sv/testbench.sv -----
// stimulus, stall patterns, watchdog and verdict for the md5 core
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_TARGET = 1700;
    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 300;
    localparam int HOLD_START  = 1500;
    localparam int HOLD_LEN    = 600;
    localparam int CALM_START  = 3000;
    localparam int CALM_END    = 4200;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] byte_value
    logic [0:0]  s_tuser  = 1'b0;    // [0] byte_present
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;            // [63:0] digest_half
    logic [0:0]  m_tuser;            // [0] half_index
    logic        m_tlast;
    int          pending;
    int          fail_count;
    int          items_sent = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    md5_message_digest_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    md5_digest_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    task automatic offer_beat(input logic [7:0] value, input logic present, input logic closes);
        // a window of items goes through with no sender gaps
        while ((items_sent < 400 || items_sent >= 800) && $urandom_range(0, 99) < 18) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= value;
        s_tuser[0] <= present;
        s_tlast    <= closes;
        do @(posedge i_clk); while (!s_tready);
        if (present || closes) items_sent++;
    endtask

    task automatic send_message(input int len, input logic end_on_byte);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < 4) offer_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            offer_beat(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (k == len - 1));
        end
        if (!end_on_byte || len == 0) offer_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    initial begin : stimulus
        int len;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        offer_beat(8'h00, 1'b0, 1'b1);   // empty message
        offer_beat(8'h5a, 1'b0, 1'b0);   // neither byte nor end: ignored
        offer_beat(8'h00, 1'b1, 1'b1);
        offer_beat(8'hff, 1'b1, 1'b0);
        offer_beat(8'hff, 1'b0, 1'b1);
        offer_beat(8'h61, 1'b1, 1'b0);
        offer_beat(8'h62, 1'b1, 1'b0);
        offer_beat(8'h63, 1'b1, 1'b1);
        offer_beat(8'hff, 1'b0, 1'b1);   // empty again straight after a digest

        while (items_sent < BYTE_TARGET) begin
            case ($urandom_range(0, 9))
                // around the point where the length no longer fits
                0: len = 64 * $urandom_range(0, 2) + $urandom_range(54, 57);
                // around whole blocks
                1: len = 64 * $urandom_range(1, 2) + $urandom_range(0, 2) - 1;
                2: len = $urandom_range(65, 200);
                3: len = 0;
                default: len = $urandom_range(1, 70);
            endcase
            send_message(len, 1'($urandom_range(0, 1)));
        end
        s_tvalid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin : receiver
        int cyc;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            // one long hold-off so the core backs up into its input
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN)
                m_tready <= 1'b0;
            else if (cyc >= CALM_START && cyc < CALM_END)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 18);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

endmodule
